[hdl/dsi_pkg.sv]
package dsi_pkg;

   localparam int MaxIndex = 65535;
   localparam logic [15:0] IndexLimit = (MaxIndex < 65535) ? 16'(MaxIndex) : 16'hFFFF;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;

   typedef enum logic [1:0] {
      ModeU32 = 2'd0,
      ModeU64 = 2'd1,
      ModeS32 = 2'd2,
      ModeS64 = 2'd3
   } number_mode_type;

   typedef enum logic [2:0] {
      PhaseStart = 3'b001,
      PhaseEmpty = 3'b010,
      PhaseTaken = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  char_code;
      logic        char_present;
      logic        last_char;
      logic [15:0] start_index;
   } item_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic [15:0] stop_index;
      logic        parse_ok;
   } result_type;

   typedef struct packed {
      logic [63:0] quot;
      logic [3:0]  rem;
   } limit_type;

   // range limit split into limit/10 and limit%10
   function automatic limit_type range_limit(input number_mode_type mode, input logic neg);
      limit_type lim;
      begin
         unique case (mode)
            ModeU32: begin
               lim.quot = 64'd429496729;
               lim.rem  = 4'd5;
            end
            ModeU64: begin
               lim.quot = 64'd1844674407370955161;
               lim.rem  = 4'd5;
            end
            ModeS32: begin
               lim.quot = 64'd214748364;
               lim.rem  = neg ? 4'd8 : 4'd7;
            end
            ModeS64: begin
               lim.quot = 64'd922337203685477580;
               lim.rem  = neg ? 4'd8 : 4'd7;
            end
            default: begin
               lim.quot = '0;
               lim.rem  = '0;
            end
         endcase
         return lim;
      end
   endfunction

endpackage

[hdl/dsi_csr.sv]
module dsi_csr
   import dsi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready,
   output number_mode_type number_mode
);

   number_mode_type mode_ff, mode_in;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         mode_in = number_mode_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeU32;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign pready      = 1'b1;
   assign prdata      = (paddr[2] == 1'b0) ? {30'd0, mode_ff} : 32'd0;
   assign number_mode = mode_ff;

endmodule

[hdl/dsi_core.sv]
module dsi_core
   import dsi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  number_mode_type number_mode,
   input  logic            step,
   input  item_type        item,
   output result_type      result
);

   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic        fail_ff, fail_in;

   logic        first;
   logic        signed_mode;
   logic        is_digit;
   logic [3:0]  digit;
   limit_type   lim;
   logic [63:0] mag_x10;
   logic [15:0] pos_bump;

   assign signed_mode = number_mode[1];
   assign first       = (phase_ff == PhaseStart);
   assign is_digit    = (item.char_code >= CharZero) && (item.char_code <= CharNine);
   assign digit       = 4'(item.char_code - CharZero);

   always_comb begin
      mag_in   = first ? 64'd0 : mag_ff;
      neg_in   = first ? 1'b0 : neg_ff;
      pos_in   = first ? ((item.start_index > IndexLimit) ? IndexLimit : item.start_index)
                       : pos_ff;
      fail_in  = first ? 1'b0 : fail_ff;
      phase_in = first ? PhaseEmpty : phase_ff;

      pos_bump = (pos_in < IndexLimit) ? pos_in + 16'd1 : pos_in;
      lim      = range_limit(number_mode, neg_in && signed_mode);
      mag_x10  = {mag_in[60:0], 3'b000} + {mag_in[62:0], 1'b0} + 64'(digit);

      if (item.char_present && !fail_in) begin
         if (first && (item.char_code == CharPlus)) begin
            phase_in = PhaseTaken;
            pos_in   = pos_bump;
         end else if (first && (item.char_code == CharMinus) && signed_mode) begin
            neg_in   = 1'b1;
            phase_in = PhaseTaken;
            pos_in   = pos_bump;
         end else if (!is_digit) begin
            fail_in = 1'b1;
         end else if ((mag_in > lim.quot) || ((mag_in == lim.quot) && (digit > lim.rem))) begin
            fail_in = 1'b1;
         end else begin
            mag_in   = mag_x10;
            phase_in = PhaseTaken;
            pos_in   = pos_bump;
         end
      end

      result.value_bits = (neg_in && signed_mode) ? 64'd0 - mag_in : mag_in;
      result.stop_index = pos_in;
      result.parse_ok   = !fail_in && (phase_in == PhaseTaken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         pos_ff   <= '0;
         phase_ff <= PhaseStart;
         fail_ff  <= 1'b0;
      end else if (step) begin
         if (item.last_char) begin
            mag_ff   <= '0;
            neg_ff   <= 1'b0;
            pos_ff   <= '0;
            phase_ff <= PhaseStart;
            fail_ff  <= 1'b0;
         end else begin
            mag_ff   <= mag_in;
            neg_ff   <= neg_in;
            pos_ff   <= pos_in;
            phase_ff <= phase_in;
            fail_ff  <= fail_in;
         end
      end
   end

endmodule

[hdl/decimal_string_to_integer.sv]
// A result word is offered from the result register once the last character word has moved
// from the input register through the parse step. Throughput: one character word per cycle,
// but for the stall below; the parse step (x10 add and range compare) sits between the input
// register and the result register. The input register stalls only on a last character while
// the result register is held. Reset (synchronous, active high) clears the parse state, both
// valids and the mode to unsigned 32-bit.
module decimal_string_to_integer
   import dsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_char_present,
   input  logic        req_last_char,
   input  logic [15:0] req_start_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value_bits,
   output logic [15:0] rsp_stop_index,
   output logic        rsp_parse_ok,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   number_mode_type number_mode;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       step;
   logic       out_free;

   dsi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .number_mode (number_mode)
   );

   dsi_core u_core (
      .clock       (clock),
      .reset       (reset),
      .number_mode (number_mode),
      .step        (step),
      .item        (item_ff),
      .result      (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!item_ff.last_char || out_free);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && item_ff.last_char) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.char_code    <= req_char_code;
         item_ff.char_present <= req_char_present;
         item_ff.last_char    <= req_last_char;
         item_ff.start_index  <= req_start_index;
      end
      if (step && item_ff.last_char) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_bits = rsp_ff.value_bits;
   assign rsp_stop_index = rsp_ff.stop_index;
   assign rsp_parse_ok   = rsp_ff.parse_ok;

`ifndef SYNTHESIS

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_ready |-> item_ff.last_char)
      else $error("input stage stalled on a non-final word");

   a_no_spurious_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !(in_valid_ff && item_ff.last_char) |=> !rsp_valid_ff)
      else $error("result word appeared without a final character");

   a_u32_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (number_mode == ModeU32) |-> rsp_ff.value_bits[63:32] == 32'd0)
      else $error("unsigned 32-bit result out of range");

   a_s32_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (number_mode == ModeS32) |->
         (rsp_ff.value_bits[63:31] == 33'd0) || (rsp_ff.value_bits[63:31] == {33{1'b1}}))
      else $error("signed 32-bit result not sign-extended");

`endif

endmodule
